// ===== hw/rtl/stable_priority_queue_macros.svh =====
// Assertion macros for the stable priority queue.
// Included by the top level; no other dependencies.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq check failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq check failed");

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants of the stable priority queue.
// No dependencies.
package spq_pkg;

   localparam int PRIO_W  = 32;
   localparam int COUNT_W = 7;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_DUP   = 3'd2,
      ST_FULL  = 3'd3,
      ST_NULL  = 3'd4
   } spq_status_type;

   typedef struct packed {
      logic ins;
      logic rem;
   } spq_ctrl_type;

   typedef struct packed {
      logic valid;
      logic precedes;
      logic hit;
   } spq_cell_stat_type;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One cell of the sorted entry chain: holds one entry and its valid bit.
// Depends on spq_pkg.
module spq_cell #(
   parameter int TAG_BITS  = 16,
   parameter int KIND_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_pkg::spq_ctrl_type               ctrl,
   input  logic [TAG_BITS-1:0]                 new_tag,
   input  logic [KIND_BITS-1:0]                new_kind,
   input  logic signed [spq_pkg::PRIO_W-1:0]   new_prio,
   input  logic                                left_valid,
   input  logic                                left_precedes,
   input  logic [TAG_BITS-1:0]                 left_tag,
   input  logic [KIND_BITS-1:0]                left_kind,
   input  logic signed [spq_pkg::PRIO_W-1:0]   left_prio,
   input  logic                                right_valid,
   input  logic [TAG_BITS-1:0]                 right_tag,
   input  logic [KIND_BITS-1:0]                right_kind,
   input  logic signed [spq_pkg::PRIO_W-1:0]   right_prio,
   output spq_pkg::spq_cell_stat_type          stat,
   output logic [TAG_BITS-1:0]                 tag,
   output logic [KIND_BITS-1:0]                kind,
   output logic signed [spq_pkg::PRIO_W-1:0]   prio
);

   logic                               valid_ff, valid_in;
   logic [TAG_BITS-1:0]                tag_ff, tag_in;
   logic [KIND_BITS-1:0]               kind_ff, kind_in;
   logic signed [spq_pkg::PRIO_W-1:0]  prio_ff, prio_in;
   logic                               precedes;

   assign precedes = !valid_ff || (new_prio < prio_ff) ||
                     ((new_prio == prio_ff) && (new_kind < kind_ff));

   always_comb begin
      priority if (ctrl.rem) begin
         valid_in = right_valid;
         tag_in   = right_tag;
         kind_in  = right_kind;
         prio_in  = right_prio;
      end else if (ctrl.ins && precedes && left_precedes) begin
         valid_in = left_valid;
         tag_in   = left_tag;
         kind_in  = left_kind;
         prio_in  = left_prio;
      end else if (ctrl.ins && precedes) begin
         valid_in = 1'b1;
         tag_in   = new_tag;
         kind_in  = new_kind;
         prio_in  = new_prio;
      end else begin
         valid_in = valid_ff;
         tag_in   = tag_ff;
         kind_in  = kind_ff;
         prio_in  = prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff  <= tag_in;
      kind_ff <= kind_in;
      prio_ff <= prio_in;
   end

   assign stat.valid    = valid_ff;
   assign stat.precedes = precedes;
   assign stat.hit      = valid_ff && (tag_ff == new_tag);
   assign tag  = tag_ff;
   assign kind = kind_ff;
   assign prio = prio_ff;

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: cell chain, count and response register.
// Depends on spq_pkg, spq_cell and stable_priority_queue_macros.svh.
//
// Min-first priority queue of up to CAPACITY entries, ordered by signed
// priority then kind, equal keys leaving in arrival order. Every cell
// compares the new key at once and the chain shifts right on insert or
// left on remove, so one transaction is accepted per cycle while the
// response register is free or being taken. Each transaction yields one
// response with status and the count after it; a remove returns the head
// entry. No clearing pass is needed after reset.
`include "stable_priority_queue_macros.svh"

module stable_priority_queue #(
   parameter int CAPACITY  = 64,
   parameter int TAG_BITS  = 16,
   parameter int KIND_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [TAG_BITS-1:0]                 req_item_tag,
   input  logic [KIND_BITS-1:0]                req_kind,
   input  logic signed [spq_pkg::PRIO_W-1:0]   req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic [TAG_BITS-1:0]                 rsp_out_tag,
   output logic [KIND_BITS-1:0]                rsp_out_kind,
   output logic signed [spq_pkg::PRIO_W-1:0]   rsp_out_priority,
   output logic [spq_pkg::COUNT_W-1:0]         rsp_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   spq_pkg::spq_ctrl_type              ctrl;
   spq_pkg::spq_cell_stat_type         stat [CAPACITY];
   logic [TAG_BITS-1:0]                tag_q [CAPACITY];
   logic [KIND_BITS-1:0]               kind_q [CAPACITY];
   logic signed [spq_pkg::PRIO_W-1:0]  prio_q [CAPACITY];
   logic [CAPACITY-1:0]                valid_vec;
   logic [CAPACITY-1:0]                hit_vec;

   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               rsp_valid_ff;
   spq_pkg::spq_status_type            rsp_status_ff, status_c;
   logic [TAG_BITS-1:0]                rsp_tag_ff;
   logic [KIND_BITS-1:0]               rsp_kind_ff;
   logic signed [spq_pkg::PRIO_W-1:0]  rsp_prio_ff;
   logic [spq_pkg::COUNT_W-1:0]        rsp_count_ff;
   logic                               accept;
   logic                               is_insert;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                               l_valid, l_precedes, r_valid;
      logic [TAG_BITS-1:0]                l_tag, r_tag;
      logic [KIND_BITS-1:0]               l_kind, r_kind;
      logic signed [spq_pkg::PRIO_W-1:0]  l_prio, r_prio;

      if (i == 0) begin : g_first
         assign l_valid    = 1'b0;
         assign l_precedes = 1'b0;
         assign l_tag      = req_item_tag;
         assign l_kind     = req_kind;
         assign l_prio     = req_priority_req;
      end else begin : g_mid_l
         assign l_valid    = stat[i-1].valid;
         assign l_precedes = stat[i-1].precedes;
         assign l_tag      = tag_q[i-1];
         assign l_kind     = kind_q[i-1];
         assign l_prio     = prio_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_tag   = req_item_tag;
         assign r_kind  = req_kind;
         assign r_prio  = req_priority_req;
      end else begin : g_mid_r
         assign r_valid = stat[i+1].valid;
         assign r_tag   = tag_q[i+1];
         assign r_kind  = kind_q[i+1];
         assign r_prio  = prio_q[i+1];
      end

      spq_cell #(
         .TAG_BITS  (TAG_BITS),
         .KIND_BITS (KIND_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .new_tag       (req_item_tag),
         .new_kind      (req_kind),
         .new_prio      (req_priority_req),
         .left_valid    (l_valid),
         .left_precedes (l_precedes),
         .left_tag      (l_tag),
         .left_kind     (l_kind),
         .left_prio     (l_prio),
         .right_valid   (r_valid),
         .right_tag     (r_tag),
         .right_kind    (r_kind),
         .right_prio    (r_prio),
         .stat          (stat[i]),
         .tag           (tag_q[i]),
         .kind          (kind_q[i]),
         .prio          (prio_q[i])
      );

      assign valid_vec[i] = stat[i].valid;
      assign hit_vec[i]   = stat[i].hit;
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_insert = (req_cmd == spq_pkg::CMD_INSERT);

   always_comb begin
      if (is_insert) begin
         priority if (req_item_tag == '0) begin
            status_c = spq_pkg::ST_NULL;
         end else if (|hit_vec) begin
            status_c = spq_pkg::ST_DUP;
         end else if (count_ff == CNT_W'(CAPACITY)) begin
            status_c = spq_pkg::ST_FULL;
         end else begin
            status_c = spq_pkg::ST_OK;
         end
      end else begin
         if (count_ff == '0) begin
            status_c = spq_pkg::ST_EMPTY;
         end else begin
            status_c = spq_pkg::ST_OK;
         end
      end
   end

   assign ctrl.ins = accept && is_insert && (status_c == spq_pkg::ST_OK);
   assign ctrl.rem = accept && !is_insert && (status_c == spq_pkg::ST_OK);

   always_comb begin
      priority if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_status_ff <= status_c;
         rsp_tag_ff    <= ctrl.rem ? tag_q[0] : '0;
         rsp_kind_ff   <= ctrl.rem ? kind_q[0] : '0;
         rsp_prio_ff   <= ctrl.rem ? prio_q[0] : '0;
         rsp_count_ff  <= spq_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_kind     = rsp_kind_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_count        = rsp_count_ff;

   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SPQ_ASSERT_NOW(a_valid_matches_count, clock, reset, 1'b1, $countones(valid_vec) == int'(count_ff))
   `SPQ_ASSERT_NEXT(a_remove_ok, clock, reset, ctrl.rem, rsp_valid_ff && rsp_status_ff == spq_pkg::ST_OK && count_ff == $past(count_ff) - CNT_W'(1))
   `SPQ_ASSERT_NOW(a_no_double_op, clock, reset, ctrl.ins || ctrl.rem, accept && !(ctrl.ins && ctrl.rem))

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for stable_priority_queue: drives insert and remove transactions,
// predicts each response with a sorted-array model and compares every field in order.
// Depends on spq_pkg and the stable_priority_queue RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH   = 64;
   localparam int HOLD_CYCLES   = 240;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [15:0]        tag;
      logic [7:0]         kind;
      logic signed [31:0] prio;
   } queue_entry_type;

   typedef struct {
      spq_pkg::spq_status_type status;
      logic [15:0]             tag;
      logic [7:0]              kind;
      logic signed [31:0]      prio;
      logic [6:0]              count;
   } spq_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = spq_pkg::CMD_INSERT;
   logic [15:0]         req_item_tag = '0;
   logic [7:0]          req_kind = '0;
   logic signed [31:0]  req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_status;
   logic [15:0]         rsp_out_tag;
   logic [7:0]          rsp_out_kind;
   logic signed [31:0]  rsp_out_priority;
   logic [6:0]          rsp_count;

   queue_entry_type  sorted_entries [QUEUE_DEPTH];
   int               sorted_count = 0;
   spq_result_type   pending_results [$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_requests = 0;
   int mismatch_count = 0;
   int transactions_in = 0;
   int status_seen [5];

   stable_priority_queue #(
      .CAPACITY  (QUEUE_DEPTH),
      .TAG_BITS  (16),
      .KIND_BITS (8)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_item_tag     (req_item_tag),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_priority (rsp_out_priority),
      .rsp_count        (rsp_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic spq_result_type predict_transaction(input logic cmd,
                                                          input logic [15:0] tag,
                                                          input logic [7:0] kind,
                                                          input logic signed [31:0] prio);
      spq_result_type  res;
      queue_entry_type ent;
      int              pos;
      bit              dup;
      res = '{spq_pkg::ST_OK, '0, '0, '0, '0};
      ent = '{tag, kind, prio};
      dup = 1'b0;
      if (cmd == spq_pkg::CMD_INSERT) begin
         for (int i = 0; i < sorted_count; i++)
            if (sorted_entries[i].tag == tag) dup = 1'b1;
         if (tag == '0) begin
            res.status = spq_pkg::ST_NULL;
         end else if (dup) begin
            res.status = spq_pkg::ST_DUP;
         end else if (sorted_count >= QUEUE_DEPTH) begin
            res.status = spq_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < sorted_count && (sorted_entries[pos].prio < prio ||
                   (sorted_entries[pos].prio == prio && sorted_entries[pos].kind <= kind)))
               pos++;
            for (int i = sorted_count; i > pos; i--)
               sorted_entries[i] = sorted_entries[i-1];
            sorted_entries[pos] = ent;
            sorted_count++;
         end
      end else if (sorted_count == 0) begin
         res.status = spq_pkg::ST_EMPTY;
      end else begin
         res.tag  = sorted_entries[0].tag;
         res.kind = sorted_entries[0].kind;
         res.prio = sorted_entries[0].prio;
         for (int i = 1; i < sorted_count; i++)
            sorted_entries[i-1] = sorted_entries[i];
         sorted_count--;
      end
      res.count = sorted_count[6:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: MISMATCH %s", $realtime, what);
   endtask

   always @(posedge clock) begin : response_checker
      spq_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_transaction(req_cmd, req_item_tag, req_kind, req_priority_req);
            pending_results.push_back(want);
            transactions_in++;
            status_seen[want.status]++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected response status=%0d tag=%h count=%0d",
                                         rsp_status, rsp_out_tag, rsp_count));
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status || rsp_out_tag !== want.tag ||
                   rsp_out_kind !== want.kind || rsp_out_priority !== want.prio ||
                   rsp_count !== want.count)
                  report_mismatch($sformatf({"expected status=%0d tag=%h kind=%h prio=%0d ",
                     "count=%0d, got status=%0d tag=%h kind=%h prio=%0d count=%0d"},
                     want.status, want.tag, want.kind, want.prio, want.count,
                     rsp_status, rsp_out_tag, rsp_out_kind, rsp_out_priority, rsp_count));
            end
         end
      end
   end

   always @(negedge clock) begin : response_receiver
      int hold_left;
      int hold_served;
      if (reset) begin
         hold_left = 0;
         hold_served = hold_requests;
         rsp_stall <= 1'b0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [15:0] tag, input logic [7:0] kind,
                            input logic signed [31:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_item_tag     <= tag;
      req_kind         <= kind;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_item(input int insert_pct);
      logic [15:0]        tag;
      logic [7:0]         kind;
      logic signed [31:0] prio;
      int                 r;
      r = $urandom_range(99);
      if (r < 3)       tag = '0;
      else if (r < 60) tag = 16'($urandom_range(1, 150));
      else             tag = 16'($urandom);
      kind = ($urandom_range(99) < 50) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      r = $urandom_range(99);
      if (r < 40)      prio = $urandom_range(0, 8) - 4;
      else if (r < 45) prio = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      else             prio = $urandom;
      send_item(($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE,
                tag, kind, prio);
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed_cases();
      send_item(spq_pkg::CMD_REMOVE, 16'h0000, 8'h00, 32'sh0);
      send_item(spq_pkg::CMD_INSERT, 16'h0000, 8'hff, 32'sh80000000);
      send_item(spq_pkg::CMD_INSERT, 16'hffff, 8'hff, 32'sh7fffffff);
      send_item(spq_pkg::CMD_INSERT, 16'h0001, 8'h00, 32'sh80000000);
      send_item(spq_pkg::CMD_INSERT, 16'h00a5, 8'h05, 32'sh0);
      send_item(spq_pkg::CMD_INSERT, 16'h0002, 8'h05, 32'sh0);
      send_item(spq_pkg::CMD_INSERT, 16'h0003, 8'h04, 32'sh0);
      send_item(spq_pkg::CMD_INSERT, 16'h0004, 8'hff, -32'sd1);
      send_item(spq_pkg::CMD_INSERT, 16'h0002, 8'h00, 32'sh12345678);
      send_item(spq_pkg::CMD_INSERT, 16'h5a5a, 8'hff, 32'sh7fffffff);
      repeat (9) send_item(spq_pkg::CMD_REMOVE, 16'h0000, 8'h00, 32'sh0);
   endtask

   task automatic test_random_mix(input int insert_pct, input int n_items);
      repeat (n_items) send_random_item(insert_pct);
   endtask

   task automatic test_fill_and_overflow();
      for (int i = 0; i < 80; i++)
         send_item(spq_pkg::CMD_INSERT, 16'h8000 | 16'(i), 8'($urandom_range(0, 3)),
                   $urandom_range(0, 6) - 3);
      send_item(spq_pkg::CMD_INSERT, 16'h8000, 8'h01, 32'sh0);
      send_item(spq_pkg::CMD_INSERT, 16'h0000, 8'h01, 32'sh0);
      send_item(spq_pkg::CMD_INSERT, 16'hc001, 8'h00, 32'sh80000000);
      test_random_mix(10, 70);
   endtask

   task automatic test_output_backpressure();
      @(posedge clock);
      hold_requests++;
      test_random_mix(80, 30);
   endtask

   task automatic test_drain_pause();
      test_random_mix(70, 20);
      wait_for_responses();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      rsp_idle_pct  = 55;
      test_directed_cases();
      test_random_mix(85, 110);
      test_output_backpressure();
      test_random_mix(25, 70);

      send_idle_pct = 55;
      rsp_idle_pct  = 17;
      test_fill_and_overflow();
      test_random_mix(85, 110);
      test_random_mix(25, 70);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_drain_pause();
      test_random_mix(85, 110);
      test_random_mix(25, 70);

      wait_for_responses();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

      $display("Ran %0d transactions: ok %0d, empty %0d, duplicate %0d, full %0d, null %0d",
               transactions_in, status_seen[spq_pkg::ST_OK], status_seen[spq_pkg::ST_EMPTY],
               status_seen[spq_pkg::ST_DUP], status_seen[spq_pkg::ST_FULL],
               status_seen[spq_pkg::ST_NULL]);
      $display("Mismatches counted: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
